// File: rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and constants shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int ELEM_W = 32;
	localparam int ADJ_W  = 64;
	localparam int DET_W  = 98;
	localparam int QBITS  = 32;
	localparam int NELEM  = 9;
	localparam int NPROD  = 18;

	// Element pairs whose products form the cofactors: adj[j] = p[2j] - p[2j+1]
	localparam int PROD_A [NPROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
	localparam int PROD_B [NPROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

	localparam logic [ELEM_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [ELEM_W-1:0] NEG_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [ELEM_W-1:0] a00;
		logic signed [ELEM_W-1:0] a01;
		logic signed [ELEM_W-1:0] a02;
		logic signed [ELEM_W-1:0] a10;
		logic signed [ELEM_W-1:0] a11;
		logic signed [ELEM_W-1:0] a12;
		logic signed [ELEM_W-1:0] a20;
		logic signed [ELEM_W-1:0] a21;
		logic signed [ELEM_W-1:0] a22;
	} in_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] r00;
		logic signed [ELEM_W-1:0] r01;
		logic signed [ELEM_W-1:0] r02;
		logic signed [ELEM_W-1:0] r10;
		logic signed [ELEM_W-1:0] r11;
		logic signed [ELEM_W-1:0] r12;
		logic signed [ELEM_W-1:0] r20;
		logic signed [ELEM_W-1:0] r21;
		logic signed [ELEM_W-1:0] r22;
		logic                     singular;
		logic                     saturated;
	} out_t;

	typedef struct packed {
		logic             valid;
		logic [DET_W-1:0] dmag;
		logic             dneg;
		logic             singular;
	} det_info_t;

endpackage

// File: rtl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front
// Cofactors and determinant: five pipeline stages of 32x32 products and adds.
// ----------------------------------------------------------------------------
module mi3_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  mi3_pkg::in_t                           mat,
	output mi3_pkg::det_info_t                     info,
	output logic [mi3_pkg::ADJ_W-1:0]              adj_mag [mi3_pkg::NELEM],
	output logic [mi3_pkg::NELEM-1:0]              adj_neg
);

	logic signed [mi3_pkg::ELEM_W-1:0] m [mi3_pkg::NELEM];

	logic [5:1] vld;
	logic signed [mi3_pkg::ADJ_W-1:0]   prod_s1 [mi3_pkg::NPROD];
	logic signed [mi3_pkg::ELEM_W-1:0]  row_s1 [3];
	logic signed [mi3_pkg::ELEM_W-1:0]  row_s2 [3];
	logic signed [mi3_pkg::ADJ_W-1:0]   adj_s2 [mi3_pkg::NELEM];
	logic signed [mi3_pkg::ADJ_W-1:0]   adj_s3 [mi3_pkg::NELEM];
	logic signed [mi3_pkg::ADJ_W:0]     plo_s3 [3];
	logic signed [mi3_pkg::ADJ_W-1:0]   phi_s3 [3];
	logic signed [mi3_pkg::ADJ_W-1:0]   adj_s4 [mi3_pkg::NELEM];
	logic signed [mi3_pkg::DET_W-1:0]   det_s4;
	logic signed [mi3_pkg::DET_W-1:0]   det_sum;
	logic                               dneg;
	logic [mi3_pkg::DET_W-1:0]          dmag_s5;
	logic                               dneg_s5;
	logic                               sing_s5;

	assign m[0] = mat.a00;
	assign m[1] = mat.a01;
	assign m[2] = mat.a02;
	assign m[3] = mat.a10;
	assign m[4] = mat.a11;
	assign m[5] = mat.a12;
	assign m[6] = mat.a20;
	assign m[7] = mat.a21;
	assign m[8] = mat.a22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			vld <= {vld[4:1], in_valid};
		end
	end

	// s1: pair products, s2: cofactors
	always_ff @(posedge clk) begin
		for (int k = 0; k < mi3_pkg::NPROD; k++) begin
			prod_s1[k] <= m[mi3_pkg::PROD_A[k]] * m[mi3_pkg::PROD_B[k]];
		end
		for (int r = 0; r < 3; r++) begin
			row_s1[r] <= m[r];
			row_s2[r] <= row_s1[r];
		end
		for (int j = 0; j < mi3_pkg::NELEM; j++) begin
			adj_s2[j] <= prod_s1[2*j] - prod_s1[2*j+1];
		end
	end

	// s3: split the 32x64 determinant terms into 32x32 partial products
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			plo_s3[r] <= row_s2[r] * $signed({1'b0, adj_s2[3*r][31:0]});
			phi_s3[r] <= row_s2[r] * $signed(adj_s2[3*r][63:32]);
		end
		adj_s3 <= adj_s2;
	end

	always_comb begin
		det_sum = '0;
		for (int r = 0; r < 3; r++) begin
			det_sum = det_sum + (mi3_pkg::DET_W'(phi_s3[r]) <<< 32)
				+ mi3_pkg::DET_W'(plo_s3[r]);
		end
	end

	always_ff @(posedge clk) begin
		det_s4 <= det_sum;
		adj_s4 <= adj_s3;
	end

	assign dneg = det_s4[mi3_pkg::DET_W-1];

	// s5: magnitudes and result signs
	always_ff @(posedge clk) begin
		dmag_s5 <= dneg ? mi3_pkg::DET_W'(-det_s4) : mi3_pkg::DET_W'(det_s4);
		dneg_s5 <= dneg;
		sing_s5 <= (det_s4 == '0);
		for (int j = 0; j < mi3_pkg::NELEM; j++) begin
			adj_mag[j] <= adj_s4[j][63] ? mi3_pkg::ADJ_W'(-adj_s4[j])
				: mi3_pkg::ADJ_W'(adj_s4[j]);
			adj_neg[j] <= adj_s4[j][63] ^ dneg;
		end
	end

	assign info = '{valid: vld[5], dmag: dmag_s5, dneg: dneg_s5, singular: sing_s5};

endmodule

// File: rtl/mi3_divider.sv
// ----------------------------------------------------------------------------
// mi3_divider
// Nine-lane restoring divider, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module mi3_divider #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mi3_pkg::det_info_t                info,
	input  logic [mi3_pkg::ADJ_W-1:0]         adj_mag [mi3_pkg::NELEM],
	input  logic [mi3_pkg::NELEM-1:0]         adj_neg,
	output logic                              out_valid,
	output mi3_pkg::out_t                     result
);

	localparam int QB = mi3_pkg::QBITS;
	localparam int CW = mi3_pkg::DET_W + QB + 1;

	logic [QB:0]                 vld_s;
	logic [mi3_pkg::DET_W-1:0]   dmag_s [QB+1];
	logic                        sing_s [QB+1];
	logic [mi3_pkg::NELEM-1:0]   neg_s  [QB+1];
	logic [mi3_pkg::NELEM-1:0]   ovf_s  [QB+1];
	logic [CW-1:0]               rem_s  [QB+1][mi3_pkg::NELEM];
	logic [QB-1:0]               quo_s  [QB+1][mi3_pkg::NELEM];

	logic [CW-1:0]               num    [mi3_pkg::NELEM];
	logic [CW-1:0]               dtop;
	logic [mi3_pkg::ELEM_W-1:0]  r      [mi3_pkg::NELEM];
	logic [mi3_pkg::NELEM-1:0]   sat;
	mi3_pkg::out_t               result_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_valid <= 1'b0;
		end else begin
			vld_s     <= {vld_s[QB-1:0], info.valid};
			out_valid <= vld_s[QB];
		end
	end

	// s0: scale numerators, flag quotients of 2^32 and above
	assign dtop = CW'(info.dmag) << QB;

	always_comb begin
		for (int l = 0; l < mi3_pkg::NELEM; l++) begin
			num[l] = CW'(adj_mag[l]) << (2*FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		dmag_s[0] <= info.dmag;
		sing_s[0] <= info.singular;
		neg_s[0]  <= adj_neg;
		for (int l = 0; l < mi3_pkg::NELEM; l++) begin
			rem_s[0][l] <= num[l];
			quo_s[0][l] <= '0;
			ovf_s[0][l] <= (num[l] >= dtop);
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_stage
		localparam int B = QB - 1 - i;
		logic [CW-1:0] dsh;
		logic [CW:0]   diff [mi3_pkg::NELEM];

		assign dsh = CW'(dmag_s[i]) << B;

		always_comb begin
			for (int l = 0; l < mi3_pkg::NELEM; l++) begin
				diff[l] = {1'b0, rem_s[i][l]} - {1'b0, dsh};
			end
		end

		always_ff @(posedge clk) begin
			dmag_s[i+1] <= dmag_s[i];
			sing_s[i+1] <= sing_s[i];
			neg_s[i+1]  <= neg_s[i];
			ovf_s[i+1]  <= ovf_s[i];
			for (int l = 0; l < mi3_pkg::NELEM; l++) begin
				// keep the remainder on borrow, shift in the quotient bit
				rem_s[i+1][l] <= diff[l][CW] ? rem_s[i][l] : diff[l][CW-1:0];
				quo_s[i+1][l] <= {quo_s[i][l][QB-2:0], ~diff[l][CW]};
			end
		end
	end

	always_comb begin
		for (int l = 0; l < mi3_pkg::NELEM; l++) begin
			if (neg_s[QB][l]) begin
				sat[l] = ovf_s[QB][l] || (quo_s[QB][l] > mi3_pkg::NEG_MIN);
				r[l]   = sat[l] ? mi3_pkg::NEG_MIN : -quo_s[QB][l];
			end else begin
				sat[l] = ovf_s[QB][l] || quo_s[QB][l][QB-1];
				r[l]   = sat[l] ? mi3_pkg::POS_MAX : quo_s[QB][l];
			end
			if (sing_s[QB]) begin
				r[l]   = '0;
				sat[l] = 1'b0;
			end
		end
		result_d = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8],
			sing_s[QB], |sat};
	end

	always_ff @(posedge clk) begin
		result <= result_d;
	end

endmodule

// File: rtl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Pipelined inverse of a signed fixed-point 3x3 matrix via the adjugate.
// ----------------------------------------------------------------------------
//  channel   ports                 transfer
//  input     start, busy, matrix   start high while busy low
//  output    done, result          done high, one cycle, no back pressure
//
//  One matrix may enter every cycle; busy is always low.
//  The pipeline has 5 cofactor/determinant stages, 33 divider stages
//  (a scaling stage, then one quotient bit per stage) and the output register.
//  Reset clears only the valid bits; the datapath is not reset.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mi3_pkg::in_t  matrix,
	output logic          done,
	output mi3_pkg::out_t result
);

	localparam int LAT = 6 + mi3_pkg::QBITS + 1;

	mi3_pkg::det_info_t                info;
	logic [mi3_pkg::ADJ_W-1:0]         adj_mag [mi3_pkg::NELEM];
	logic [mi3_pkg::NELEM-1:0]         adj_neg;

	assign busy = 1'b0;

	mi3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.mat      (matrix),
		.info     (info),
		.adj_mag  (adj_mag),
		.adj_neg  (adj_neg)
	);

	mi3_divider #(
		.FRAC_BITS (FRAC_BITS)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.info      (info),
		.adj_mag   (adj_mag),
		.adj_neg   (adj_neg),
		.out_valid (done),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching start");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.singular |-> result.r00 == '0 && result.r11 == '0
			&& result.r22 == '0 && result.r01 == '0 && result.r20 == '0)
		else $error("singular result carries nonzero elements");

	a_singular_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.singular && result.saturated))
		else $error("singular and saturated both set");
`endif

endmodule
